// File: sv/vec4_arithmetic_unit_defines.svh
// ----------------------------------------------------------------------------
// vec4 arithmetic unit assertion macros
// shorthand for the clocked checks used by the port checker
// ----------------------------------------------------------------------------
`ifndef VEC4_ARITHMETIC_UNIT_DEFINES_SVH
`define VEC4_ARITHMETIC_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define VAU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication after a fixed number of cycles
`define VAU_ASSERT_DLY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
        else $error(msg);

`endif

// File: sv/vau_pkg.sv
// ----------------------------------------------------------------------------
// vau_pkg
// item types, opcodes and fixed widths of the vec4 arithmetic unit
// ----------------------------------------------------------------------------
package vau_pkg;

    // opcodes
    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_NEG   = 3'd2;
    localparam logic [2:0] OP_SCALE = 3'd3;
    localparam logic [2:0] OP_NORM  = 3'd4;
    localparam logic [2:0] OP_PERSP = 3'd5;
    localparam logic [2:0] OP_LEN   = 3'd6;

    // saturation limits
    localparam logic [31:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_MIN = 32'h8000_0000;

    // root pipeline: one result bit per stage
    localparam int SQRT_STEPS = 32;
    // divider: quotient bits, divisor and remainder widths
    localparam int QUOT_W = 33;
    localparam int DEN_W  = 33;
    localparam int REM_W  = 34;

    // cycles from accepted item to done
    localparam int PIPE_LAT = SQRT_STEPS + QUOT_W + 4;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] a_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] b_w;
        logic signed [31:0] scale_factor;
    } vau_in_t;

    typedef struct packed {
        logic signed [31:0] r_x;
        logic signed [31:0] r_y;
        logic signed [31:0] r_z;
        logic signed [31:0] r_w;
        logic [31:0]        magnitude;
        logic               fault;
    } vau_out_t;

endpackage

// File: sv/vau_isqrt.sv
// ----------------------------------------------------------------------------
// vau_isqrt
// pipelined integer square root of a 64-bit value, one root bit per stage
// ----------------------------------------------------------------------------
module vau_isqrt (
    input  logic        clk,
    input  logic [63:0] radicand,
    output logic [31:0] root
);

    localparam int STEPS = vau_pkg::SQRT_STEPS;

    logic [33:0] rem_reg   [STEPS];
    logic [31:0] root_reg  [STEPS];
    logic [63:0] rad_reg   [STEPS];
    logic [33:0] rem_next  [STEPS];
    logic [31:0] root_next [STEPS];
    logic [63:0] rad_next  [STEPS];

    // one restoring root step per stage
    always_comb
    begin
        logic [33:0] rem_in;
        logic [33:0] rem_sh;
        logic [33:0] trial;
        logic [31:0] root_in;
        logic [63:0] rad_in;
        logic        ge;
        for (int k = 0; k < STEPS; k++)
        begin
            if (k == 0)
            begin
                rem_in  = '0;
                root_in = '0;
                rad_in  = radicand;
            end
            else
            begin
                rem_in  = rem_reg[k-1];
                root_in = root_reg[k-1];
                rad_in  = rad_reg[k-1];
            end
            rem_sh       = {rem_in[31:0], rad_in[63:62]};
            trial        = {root_in, 2'b01};
            ge           = (rem_sh >= trial);
            rem_next[k]  = ge ? (rem_sh - trial) : rem_sh;
            root_next[k] = {root_in[30:0], ge};
            rad_next[k]  = {rad_in[61:0], 2'b00};
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < STEPS; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
            rad_reg[k]  <= rad_next[k];
        end
    end

    assign root = root_reg[STEPS-1];

endmodule

// File: sv/vau_div.sv
// ----------------------------------------------------------------------------
// vau_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module vau_div #(
    parameter int NUM_W = 48
) (
    input  logic                       clk,
    input  logic [NUM_W-1:0]           num,
    input  logic [vau_pkg::DEN_W-1:0]  den,
    output logic [vau_pkg::QUOT_W-1:0] quot
);

    localparam int QW    = vau_pkg::QUOT_W;
    localparam int DW    = vau_pkg::DEN_W;
    localparam int RW    = vau_pkg::REM_W;

    logic [RW-1:0] rem_reg   [QW];
    logic [QW-1:0] low_reg   [QW];
    logic [QW-1:0] quot_reg  [QW];
    logic [DW-1:0] den_reg   [QW];
    logic [RW-1:0] rem_next  [QW];
    logic [QW-1:0] low_next  [QW];
    logic [QW-1:0] quot_next [QW];
    logic [DW-1:0] den_next  [QW];

    // one shift and trial subtract per stage
    always_comb
    begin
        logic [RW-1:0] rem_in;
        logic [RW-1:0] rem_sh;
        logic [RW-1:0] den_x;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quot_in;
        logic [DW-1:0] den_in;
        logic          ge;
        for (int k = 0; k < QW; k++)
        begin
            if (k == 0)
            begin
                rem_in  = RW'(num[NUM_W-1:QW]);
                low_in  = num[QW-1:0];
                quot_in = '0;
                den_in  = den;
            end
            else
            begin
                rem_in  = rem_reg[k-1];
                low_in  = low_reg[k-1];
                quot_in = quot_reg[k-1];
                den_in  = den_reg[k-1];
            end
            rem_sh       = {rem_in[RW-2:0], low_in[QW-1]};
            den_x        = RW'(den_in);
            ge           = (rem_sh >= den_x);
            rem_next[k]  = ge ? (rem_sh - den_x) : rem_sh;
            low_next[k]  = {low_in[QW-2:0], 1'b0};
            quot_next[k] = {quot_in[QW-2:0], ge};
            den_next[k]  = den_in;
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < QW; k++)
        begin
            rem_reg[k]  <= rem_next[k];
            low_reg[k]  <= low_next[k];
            quot_reg[k] <= quot_next[k];
            den_reg[k]  <= den_next[k];
        end
    end

    assign quot = quot_reg[QW-1];

endmodule

// File: sv/vec4_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// vec4_arithmetic_unit
// four-component signed fixed-point vector unit: add, sub, negate, scale,
// normalize, perspective divide and length, with saturation and fault flag
// ----------------------------------------------------------------------------
// channel   | handshake        | payload
// ----------+------------------+---------------------------
// item in   | start, busy      | operands (vau_in_t)
// item out  | done (one cycle) | result (vau_out_t)
//
// one item per cycle, every cycle; busy stays low.
// the path runs through the multiply and sum registers, the square root
// stages, the divisor setup register, the divide stages and the output
// register. root and divide stages each resolve one bit.
// reset clears all valid bits; results go out without backpressure.
// ----------------------------------------------------------------------------
module vec4_arithmetic_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  vau_pkg::vau_in_t  operands,
    output logic              done,
    output vau_pkg::vau_out_t result
);

    localparam int NUM_W = 32 + FRAC_BITS;
    localparam int QW    = vau_pkg::QUOT_W;
    localparam int DW    = vau_pkg::DEN_W;
    localparam int RW    = vau_pkg::REM_W;
    localparam int SQ_N  = vau_pkg::SQRT_STEPS;
    localparam logic [63:0] ROUND_HALF = 64'd1 << (FRAC_BITS - 1);

    // sideband that travels with each item
    typedef struct packed {
        logic [2:0]       kind;
        logic [3:0][31:0] mag_a;
        logic [3:0]       a_neg;
        logic [3:0]       a_nz;
        logic [3:0][31:0] lin;
        logic             lin_fault;
        logic             len_carry;
        logic             len_zero;
        logic [3:0]       ovf;
        logic [31:0]      magnitude;
    } ctx_t;

    logic [3:0][31:0] in_a;
    logic [3:0][31:0] in_b;

    ctx_t             ctx0;
    logic [3:0][63:0] sq0;
    logic [3:0][63:0] sprod0;
    logic             sneg0;

    logic             p1_vld_reg;
    ctx_t             p1_ctx_reg;
    logic [3:0][63:0] p1_sq_reg;
    logic [3:0][63:0] p1_sprod_reg;
    logic             p1_sneg_reg;

    ctx_t             ctx1;
    logic [64:0]      sum1;

    logic             p2_vld_reg;
    ctx_t             p2_ctx_reg;
    logic [64:0]      p2_sum_reg;

    logic [31:0]      root;
    logic [SQ_N-1:0]  l1_vld_reg;
    ctx_t             l1_ctx_reg [SQ_N];

    ctx_t                   ctxp;
    logic [3:0][NUM_W-1:0]  nump;
    logic [DW-1:0]          denp;

    logic                   pp_vld_reg;
    ctx_t                   pp_ctx_reg;
    logic [3:0][NUM_W-1:0]  pp_num_reg;
    logic [DW-1:0]          pp_den_reg;

    logic [3:0][QW-1:0]     quot;
    logic [QW-1:0]          l2_vld_reg;
    ctx_t                   l2_ctx_reg [QW];

    vau_pkg::vau_out_t      res_next;
    vau_pkg::vau_out_t      res_reg;
    logic                   done_reg;

    assign busy = 1'b0;
    assign in_a = {operands.a_w, operands.a_z, operands.a_y, operands.a_x};
    assign in_b = {operands.b_w, operands.b_z, operands.b_y, operands.b_x};

    // stage 0: magnitudes, squares, scale products, add/sub/negate
    always_comb
    begin
        logic [32:0] ea;
        logic [32:0] eb;
        logic [32:0] s;
        logic [31:0] mag_s;
        ctx0      = '0;
        ctx0.kind = operands.kind;
        sneg0     = operands.scale_factor[31];
        mag_s     = operands.scale_factor[31] ? (32'd0 - operands.scale_factor)
                                              : operands.scale_factor;
        for (int i = 0; i < 4; i++)
        begin
            ctx0.a_neg[i] = in_a[i][31];
            ctx0.a_nz[i]  = |in_a[i];
            ctx0.mag_a[i] = in_a[i][31] ? (32'd0 - in_a[i]) : in_a[i];
            sq0[i]        = ctx0.mag_a[i] * ctx0.mag_a[i];
            sprod0[i]     = ctx0.mag_a[i] * mag_s;
            ea = {in_a[i][31], in_a[i]};
            eb = {in_b[i][31], in_b[i]};
            case (operands.kind)
                vau_pkg::OP_SUB: s = ea - eb;
                vau_pkg::OP_NEG: s = 33'd0 - ea;
                default:         s = ea + eb;
            endcase
            if (s[32] != s[31])
            begin
                ctx0.lin[i]    = s[32] ? vau_pkg::SAT_MIN : vau_pkg::SAT_MAX;
                ctx0.lin_fault = 1'b1;
            end
            else
            begin
                ctx0.lin[i] = s[31:0];
            end
        end
    end

    // valid bits of every stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            pp_vld_reg <= 1'b0;
            l1_vld_reg <= '0;
            l2_vld_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= start & ~busy;
            p2_vld_reg <= p1_vld_reg;
            l1_vld_reg <= {l1_vld_reg[SQ_N-2:0], p2_vld_reg};
            pp_vld_reg <= l1_vld_reg[SQ_N-1];
            l2_vld_reg <= {l2_vld_reg[QW-2:0], pp_vld_reg};
            done_reg   <= l2_vld_reg[QW-1];
        end
    end

    // stage 1 data
    always_ff @(posedge clk)
    begin
        p1_ctx_reg   <= ctx0;
        p1_sq_reg    <= sq0;
        p1_sprod_reg <= sprod0;
        p1_sneg_reg  <= sneg0;
    end

    // stage 1: sum of squares, scale rounding and saturation
    always_comb
    begin
        logic [63:0] rq;
        logic [63:0] lim;
        logic        neg;
        logic        sat;
        logic [31:0] val;
        ctx1 = p1_ctx_reg;
        sum1 = 65'(p1_sq_reg[0]) + 65'(p1_sq_reg[1])
             + 65'(p1_sq_reg[2]) + 65'(p1_sq_reg[3]);
        ctx1.len_carry = sum1[64];
        if (p1_ctx_reg.kind == vau_pkg::OP_SCALE)
        begin
            ctx1.lin_fault = 1'b0;
        end
        for (int i = 0; i < 4; i++)
        begin
            rq  = (p1_sprod_reg[i] + ROUND_HALF) >> FRAC_BITS;
            neg = p1_ctx_reg.a_neg[i] ^ p1_sneg_reg;
            lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            sat = (rq > lim);
            if (sat)
            begin
                val = neg ? vau_pkg::SAT_MIN : vau_pkg::SAT_MAX;
            end
            else
            begin
                val = neg ? (32'd0 - rq[31:0]) : rq[31:0];
            end
            if (p1_ctx_reg.kind == vau_pkg::OP_SCALE)
            begin
                ctx1.lin[i]    = val;
                ctx1.lin_fault = ctx1.lin_fault | sat;
            end
        end
    end

    // stage 2 data
    always_ff @(posedge clk)
    begin
        p2_ctx_reg <= ctx1;
        p2_sum_reg <= sum1;
    end

    // square root of the sum of squares
    vau_isqrt u_isqrt (
        .clk      (clk),
        .radicand (p2_sum_reg[63:0]),
        .root     (root)
    );

    // sideband delay matching the root pipeline
    always_ff @(posedge clk)
    begin
        l1_ctx_reg[0] <= p2_ctx_reg;
        for (int k = 1; k < SQ_N; k++)
        begin
            l1_ctx_reg[k] <= l1_ctx_reg[k-1];
        end
    end

    // divisor setup: length or |w|, rounded dividend, overflow check
    always_comb
    begin
        logic [DW-1:0] len;
        ctxp = l1_ctx_reg[SQ_N-1];
        len  = ctxp.len_carry ? {1'b1, 32'd0} : {1'b0, root};
        ctxp.len_zero  = (len == '0);
        ctxp.magnitude = ctxp.len_carry ? 32'hFFFF_FFFF : root;
        denp = (ctxp.kind == vau_pkg::OP_NORM) ? len : DW'(ctxp.mag_a[3]);
        for (int i = 0; i < 4; i++)
        begin
            nump[i] = {ctxp.mag_a[i], FRAC_BITS'(0)} + NUM_W'(denp >> 1);
            ctxp.ovf[i] = (RW'(nump[i][NUM_W-1:QW]) >= RW'(denp));
        end
    end

    always_ff @(posedge clk)
    begin
        pp_ctx_reg <= ctxp;
        pp_num_reg <= nump;
        pp_den_reg <= denp;
    end

    // one divider lane per component
    for (genvar g = 0; g < 4; g++)
    begin : g_div
        vau_div #(
            .NUM_W (NUM_W)
        ) u_div (
            .clk  (clk),
            .num  (pp_num_reg[g]),
            .den  (pp_den_reg),
            .quot (quot[g])
        );
    end

    // sideband delay matching the divider
    always_ff @(posedge clk)
    begin
        l2_ctx_reg[0] <= pp_ctx_reg;
        for (int k = 1; k < QW; k++)
        begin
            l2_ctx_reg[k] <= l2_ctx_reg[k-1];
        end
    end

    // final select: sign, saturation, per-kind result
    always_comb
    begin
        ctx_t             c;
        logic [3:0][31:0] dv;
        logic [3:0][31:0] wv;
        logic [3:0][31:0] r;
        logic [3:0]       dsat;
        logic             neg;
        logic [QW-1:0]    lim;
        logic             flt;
        c = l2_ctx_reg[QW-1];
        for (int i = 0; i < 4; i++)
        begin
            neg = c.a_neg[i] ^ ((c.kind == vau_pkg::OP_PERSP) & c.a_neg[3]);
            lim = neg ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
            dsat[i] = c.ovf[i] | (quot[i] > lim);
            if (dsat[i])
            begin
                dv[i] = neg ? vau_pkg::SAT_MIN : vau_pkg::SAT_MAX;
            end
            else
            begin
                dv[i] = neg ? (32'd0 - quot[i][31:0]) : quot[i][31:0];
            end
            wv[i] = c.a_neg[i] ? vau_pkg::SAT_MIN
                               : (c.a_nz[i] ? vau_pkg::SAT_MAX : 32'd0);
        end
        unique case (c.kind) inside
            vau_pkg::OP_ADD, vau_pkg::OP_SUB, vau_pkg::OP_NEG, vau_pkg::OP_SCALE:
            begin
                r   = c.lin;
                flt = c.lin_fault;
            end
            vau_pkg::OP_NORM:
            begin
                r   = c.len_zero ? '0 : dv;
                flt = 1'b0;
            end
            vau_pkg::OP_PERSP:
            begin
                if (!c.a_nz[3])
                begin
                    r   = wv;
                    flt = 1'b1;
                end
                else
                begin
                    r   = dv;
                    flt = |dsat;
                end
            end
            vau_pkg::OP_LEN:
            begin
                r   = '0;
                flt = c.len_carry;
            end
            default:
            begin
                r   = '0;
                flt = 1'b0;
            end
        endcase
        res_next.r_x       = r[0];
        res_next.r_y       = r[1];
        res_next.r_z       = r[2];
        res_next.r_w       = r[3];
        res_next.magnitude = c.magnitude;
        res_next.fault     = flt;
    end

    // output register
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

// File: sv/vau_checker.sv
// ----------------------------------------------------------------------------
// vau_checker
// port-level checks of item timing and result rules, bound to the top level
// ----------------------------------------------------------------------------
`include "vec4_arithmetic_unit_defines.svh"

module vau_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              start,
    input logic              busy,
    input vau_pkg::vau_in_t  operands,
    input logic              done,
    input vau_pkg::vau_out_t result
);

    localparam int LAT = vau_pkg::PIPE_LAT;

    // every accepted item comes out after the fixed latency
    `VAU_ASSERT_DLY(a_item_out, start && !busy, LAT, done, "accepted item produced no result")

    // no result without an item accepted at the matching edge
    `VAU_ASSERT_NOW(a_no_spurious, done, $past(start && !busy, LAT), "result without item")

    // length items return a zero vector
    `VAU_ASSERT_NOW(a_len_zero, done && $past(start && !busy && operands.kind == vau_pkg::OP_LEN, LAT), result.r_x == 0 && result.r_y == 0 && result.r_z == 0 && result.r_w == 0, "length item gave nonzero vector")

    // normalize never faults
    `VAU_ASSERT_NOW(a_norm_clean, done && $past(start && !busy && operands.kind == vau_pkg::OP_NORM, LAT), !result.fault, "normalize item faulted")

endmodule

bind vec4_arithmetic_unit vau_checker u_vau_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .operands (operands),
    .done     (done),
    .result   (result)
);
